FILE: rtl/core/cmrt_pkg.sv
`timescale 1ns / 1ps

package cmrt_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_SINGLE_DONE = 3'd0,
    ST_START_OPEN  = 3'd1,
    ST_CONTINUED   = 3'd2,
    ST_MULTI_DONE  = 3'd3,
    ST_TOO_SHORT   = 3'd4,
    ST_OVERLENGTH  = 3'd5,
    ST_NO_CHANNEL  = 3'd6
  } status_t;

  // Frame class after decode.
  typedef enum logic [1:0] {
    K_SHORT  = 2'd0,
    K_SINGLE = 2'd1,
    K_START  = 2'd2,
    K_CONT   = 2'd3
  } kind_t;

  localparam int unsigned HdrW   = 15;
  localparam int unsigned LenW   = 12;
  localparam int unsigned DataW  = 64;
  localparam int unsigned CountW = 3;

  // Decoded view of one frame.
  typedef struct packed {
    kind_t               kind;
    logic [1:0]          ch;
    logic [HdrW-1:0]     hdr;
    logic [LenW-1:0]     total;
    logic [CountW-1:0]   n;
    logic [DataW-1:0]    payload;
  } dec_t;

  // One result item.
  typedef struct packed {
    status_t             status;
    logic [1:0]          channel;
    logic [2:0]          op_code;
    logic [5:0]          node_id;
    logic [5:0]          port_id;
    logic [LenW-1:0]     total_length;
    logic [LenW-1:0]     byte_offset;
    logic [DataW-1:0]    payload;
    logic [CountW-1:0]   payload_count;
    logic                replaced_open;
  } res_t;

  // Keeps the top n bytes of a 64-bit word.
  function automatic logic [DataW-1:0] byte_mask(input logic [CountW-1:0] n);
    logic [DataW-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[DataW-1-8*i -: 8] = (4'(i) < {1'b0, n}) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/cmrt_frame_classify.sv
`timescale 1ns / 1ps

module cmrt_frame_classify (
  input  logic [3:0]          frame_len,
  input  logic [63:0]         frame_bytes,
  output cmrt_pkg::dec_t      dec
);

  logic [3:0] len_c;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;
  logic [7:0] b3;
  logic       multi;
  logic       cont;
  logic [63:0] shifted;
  logic [3:0] n_full;

  assign b0 = frame_bytes[63:56];
  assign b1 = frame_bytes[55:48];
  assign b2 = frame_bytes[47:40];
  assign b3 = frame_bytes[39:32];
  assign multi = b0[7];
  assign cont  = b0[6];

  // Lengths above eight count as eight.
  assign len_c = (frame_len > 4'd8) ? 4'd8 : frame_len;

  // Classify the frame and pick out header, declared length and payload.
  always_comb begin
    dec         = '0;
    dec.ch      = multi ? b0[5:4] : 2'd0;
    dec.total   = {b0[3:0], b1};
    n_full      = 4'd0;
    shifted     = '0;
    if ((len_c < 4'd2) || (multi && !cont && (len_c < 4'd4))) begin
      dec.kind = cmrt_pkg::K_SHORT;
    end else if (!multi) begin
      dec.kind  = cmrt_pkg::K_SINGLE;
      dec.hdr   = {b0[6:0], b1};
      n_full    = len_c - 4'd2;
      shifted   = frame_bytes << 16;
    end else if (!cont) begin
      dec.kind  = cmrt_pkg::K_START;
      dec.hdr   = {b2[6:0], b3};
      n_full    = len_c - 4'd4;
      shifted   = frame_bytes << 32;
    end else begin
      dec.kind  = cmrt_pkg::K_CONT;
      n_full    = len_c - 4'd1;
      shifted   = frame_bytes << 8;
    end
    dec.n       = n_full[2:0];
    dec.payload = shifted & cmrt_pkg::byte_mask(n_full[2:0]);
  end

endmodule

FILE: rtl/core/cmrt_chan_tracker.sv
`timescale 1ns / 1ps

module cmrt_chan_tracker #(
  parameter int CHANNELS = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  cmrt_pkg::dec_t  dec,
  output cmrt_pkg::res_t  res
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                       open_r  [CHANNELS];
  logic [cmrt_pkg::LenW-1:0]  total_r [CHANNELS];
  logic [cmrt_pkg::LenW-1:0]  done_r  [CHANNELS];
  logic [cmrt_pkg::HdrW-1:0]  hdr_r   [CHANNELS];

  logic [IdxW-1:0]            idx;
  logic                       chan_ok;
  logic                       ent_open;
  logic [cmrt_pkg::LenW-1:0]  ent_total;
  logic [cmrt_pkg::LenW-1:0]  ent_done;
  logic [cmrt_pkg::HdrW-1:0]  ent_hdr;
  logic [cmrt_pkg::LenW:0]    sum;
  logic [cmrt_pkg::LenW-1:0]  n_ext;

  logic                       open_we;
  logic                       open_nxt;
  logic                       ent_we;
  logic                       done_we;
  logic [cmrt_pkg::LenW-1:0]  done_nxt;

  // Channel lookup; entries past CHANNELS do not exist.
  assign idx     = IdxW'(dec.ch);
  assign chan_ok = ({1'b0, dec.ch} < 3'(CHANNELS));
  assign ent_open  = chan_ok && open_r[idx];
  assign ent_total = total_r[idx];
  assign ent_done  = done_r[idx];
  assign ent_hdr   = hdr_r[idx];
  assign n_ext     = cmrt_pkg::LenW'(dec.n);
  assign sum       = {1'b0, ent_done} + {1'b0, n_ext};

  // Result and channel update for one frame.
  always_comb begin
    res          = '0;
    res.status   = cmrt_pkg::ST_TOO_SHORT;
    res.channel  = dec.ch;
    open_we      = 1'b0;
    open_nxt     = 1'b0;
    ent_we       = 1'b0;
    done_we      = 1'b0;
    done_nxt     = n_ext;
    case (dec.kind)
      cmrt_pkg::K_SHORT: begin
        res.status = cmrt_pkg::ST_TOO_SHORT;
      end
      cmrt_pkg::K_SINGLE: begin
        res.status        = cmrt_pkg::ST_SINGLE_DONE;
        res.op_code       = dec.hdr[14:12];
        res.node_id       = dec.hdr[11:6];
        res.port_id       = dec.hdr[5:0];
        res.total_length  = n_ext;
        res.payload       = dec.payload;
        res.payload_count = dec.n;
      end
      cmrt_pkg::K_START: begin
        if (!chan_ok) begin
          res.status = cmrt_pkg::ST_NO_CHANNEL;
        end else begin
          res.replaced_open = ent_open;
          res.op_code       = dec.hdr[14:12];
          res.node_id       = dec.hdr[11:6];
          res.port_id       = dec.hdr[5:0];
          res.total_length  = dec.total;
          open_we           = 1'b1;
          if (n_ext > dec.total) begin
            res.status = cmrt_pkg::ST_OVERLENGTH;
          end else begin
            res.payload       = dec.payload;
            res.payload_count = dec.n;
            if (n_ext == dec.total) begin
              res.status = cmrt_pkg::ST_MULTI_DONE;
            end else begin
              res.status = cmrt_pkg::ST_START_OPEN;
              open_nxt   = 1'b1;
              ent_we     = 1'b1;
            end
          end
        end
      end
      cmrt_pkg::K_CONT: begin
        if (!ent_open) begin
          res.status = cmrt_pkg::ST_NO_CHANNEL;
        end else begin
          res.op_code      = ent_hdr[14:12];
          res.node_id      = ent_hdr[11:6];
          res.port_id      = ent_hdr[5:0];
          res.total_length = ent_total;
          res.byte_offset  = ent_done;
          if (sum > {1'b0, ent_total}) begin
            res.status = cmrt_pkg::ST_OVERLENGTH;
            open_we    = 1'b1;
          end else begin
            res.payload       = dec.payload;
            res.payload_count = dec.n;
            done_we           = 1'b1;
            done_nxt          = sum[cmrt_pkg::LenW-1:0];
            if (sum[cmrt_pkg::LenW-1:0] == ent_total) begin
              res.status = cmrt_pkg::ST_MULTI_DONE;
              open_we    = 1'b1;
            end else begin
              res.status = cmrt_pkg::ST_CONTINUED;
            end
          end
        end
      end
      default: begin
        res.status = cmrt_pkg::ST_TOO_SHORT;
      end
    endcase
  end

  // Open flags are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        open_r[i] <= 1'b0;
      end
    end else if (fire && open_we) begin
      open_r[idx] <= open_nxt;
    end
  end

  // Message bookkeeping is only read while the channel is open.
  always_ff @(posedge clk) begin
    if (fire && ent_we) begin
      total_r[idx] <= dec.total;
      hdr_r[idx]   <= dec.hdr;
    end
    if (fire && (ent_we || done_we)) begin
      done_r[idx] <= done_nxt;
    end
  end

endmodule

FILE: rtl/core/can_multiframe_reassembly_tracker.sv
`timescale 1ns / 1ps

// Tracks multi-frame CAN messages on up to four channels. Each accepted frame
// (length in in_tdata[3:0], data bytes in in_tdata[67:4], byte 0 on top)
// yields exactly one result carrying the payload bytes, their offset in the
// message, the decoded header and a status. A frame passes through an input
// register and then a result register, where its result is presented; a new
// frame is taken every cycle while the result side keeps up. The channel table
// is read and written in the same cycle, which sets that one-frame-per-cycle
// rate.
module can_multiframe_reassembly_tracker #(
  parameter int CHANNELS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // frame_len[3:0], frame_bytes[67:4], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // op_code, node_id, port_id, total_length,
                                   // byte_offset, payload, payload_count,
                                   // replaced_open, zero pad
  output logic [4:0]   out_tuser   // status[2:0], channel[4:3]
);

  logic                 in_valid_r;
  logic [3:0]           in_len_r;
  logic [63:0]          in_bytes_r;
  logic                 out_valid_r;
  cmrt_pkg::res_t       out_res_r;
  cmrt_pkg::dec_t       dec;
  cmrt_pkg::res_t       res;
  logic                 advance;

  // The held frame moves on when the result register is free or draining.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!in_valid_r || advance);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_len_r   <= in_tdata[3:0];
      in_bytes_r <= in_tdata[67:4];
    end
  end

  cmrt_frame_classify u_classify (
    .frame_len   (in_len_r),
    .frame_bytes (in_bytes_r),
    .dec         (dec)
  );

  cmrt_chan_tracker #(
    .CHANNELS (CHANNELS)
  ) u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .dec   (dec),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.channel, out_res_r.status};
  assign out_tdata  = {5'b0,
                       out_res_r.replaced_open,
                       out_res_r.payload_count,
                       out_res_r.payload,
                       out_res_r.byte_offset,
                       out_res_r.total_length,
                       out_res_r.port_id,
                       out_res_r.node_id,
                       out_res_r.op_code};

endmodule
